// ===== hdl/pkr_pkg.sv =====
// word chunk packer package: constants, item and descriptor types, byte classifier
// used by every packer module but pkr_ram; depends on nothing
package pkr_pkg;

  localparam int MAX_WORD = 63;
  localparam int LEN_W = $clog2(MAX_WORD + 1);
  localparam int BUF_AW = LEN_W + 1;
  localparam int BUF_DEPTH = 2 ** BUF_AW;
  localparam int CFG_W = 32;
  localparam logic [CFG_W-1:0] CHUNK_LIMIT_RESET = 32'd64;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // queue depths are powers of two so pointers wrap on their own
  localparam int DQ_DEPTH = 2;
  localparam int DQ_PW = $clog2(DQ_DEPTH);
  localparam int DQ_CW = $clog2(DQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW = $clog2(OQ_DEPTH);
  localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CLS_WORD,
    CLS_SPACE,
    CLS_PUNCT
  } byte_class_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_NEWLINE
  } back_state_t;

  // one finished word (or end of text) handed from front to back
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             eot;
  } desc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       dropped;
    logic       last;
  } result_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t cls;
    cls = CLS_WORD;
    if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
      cls = CLS_SPACE;
    end else if ((b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
                 (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E)) begin
      cls = CLS_PUNCT;
    end
    return cls;
  endfunction

endpackage

// ===== hdl/pkr_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module pkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pkr_front.sv =====
// packer front end: accepts text items, classifies bytes, fills the word buffer
// and hands finished words to the descriptor queue; uses pkr_pkg
module pkr_front
  import pkr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output desc_t             q_din,
  output logic              buf_we,
  output logic [BUF_AW-1:0] buf_waddr,
  output logic [7:0]        buf_wdata
);

  logic             accept;
  byte_class_t      cls;
  logic             bank, bank_next;
  logic [LEN_W-1:0] word_length, word_length_next;
  logic             word_overflow, word_overflow_next;

  assign full = q_full;
  assign accept = push && !q_full;
  assign cls = classify(in_byte);

  assign q_din = '{bank: bank, len: word_length, ovf: word_overflow, eot: end_of_text};
  assign buf_waddr = {bank, word_length};
  assign buf_wdata = in_byte;

  always_comb begin
    bank_next = bank;
    word_length_next = word_length;
    word_overflow_next = word_overflow;
    q_push = 1'b0;
    buf_we = 1'b0;
    if (accept) begin
      if (end_of_text) begin
        // always queued, even with no word, so the chunk fill clears in order
        q_push = 1'b1;
      end else begin
        unique case (cls)
          CLS_SPACE: begin
            q_push = (word_length != '0) || word_overflow;
          end
          CLS_PUNCT: begin
          end
          CLS_WORD: begin
            if (word_overflow || word_length == LEN_W'(MAX_WORD)) begin
              word_overflow_next = 1'b1;
            end else begin
              buf_we = 1'b1;
              word_length_next = word_length + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (q_push) begin
        bank_next = ~bank;
        word_length_next = '0;
        word_overflow_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      word_length <= '0;
      word_overflow <= 1'b0;
    end else begin
      bank <= bank_next;
      word_length <= word_length_next;
      word_overflow <= word_overflow_next;
    end
  end

endmodule

// ===== hdl/pkr_queue.sv =====
// two-entry descriptor queue between packer front and back
// uses pkr_pkg
module pkr_queue
  import pkr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t din,
  input  logic  pop,
  output desc_t dout,
  output logic  full,
  output logic  not_empty
);

  desc_t            entries [DQ_DEPTH];
  logic [DQ_PW-1:0] wr_ptr, rd_ptr;
  logic [DQ_CW-1:0] count;
  logic             do_push, do_pop;

  assign full = (count == DQ_CW'(DQ_DEPTH));
  assign not_empty = (count != '0);
  assign dout = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pkr_back.sv =====
// packer back end: places words into chunks, reads the word buffer out and
// queues result items toward the output; holds chunk_limit; uses pkr_pkg
module pkr_back
  import pkr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              q_not_empty,
  input  desc_t             q_head,
  output logic              q_pop,
  output logic              buf_re,
  output logic [BUF_AW-1:0] buf_raddr,
  input  logic [7:0]        buf_rdata,
  output logic              empty,
  input  logic              pop,
  output result_t           head
);

  back_state_t      state, state_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic             start_flag, start_flag_next;
  logic [CFG_W-1:0] chunk_fill, chunk_fill_next;
  logic [CFG_W-1:0] chunk_limit;
  logic             rd_pend, rd_first;

  result_t          oq [OQ_DEPTH];
  logic [OQ_PW-1:0] oq_wr, oq_rd;
  logic [OQ_CW-1:0] oq_count;
  logic             oq_push, oq_pop;
  result_t          oq_din;

  logic             room, word_empty, too_long, fresh;
  logic             drop_push, nl_push;
  logic [LEN_W:0]   need;
  logic [CFG_W:0]   fill_sum;

  // count reads in flight so a stalled receiver never overflows the queue
  assign room = ({1'b0, oq_count} + (OQ_CW + 1)'(rd_pend)) < (OQ_CW + 1)'(OQ_DEPTH);
  assign need = {1'b0, q_head.len} + 1'b1;
  assign fill_sum = {1'b0, chunk_fill} + (CFG_W + 1)'(need);
  assign word_empty = (q_head.len == '0) && !q_head.ovf;
  assign too_long = q_head.ovf || ((CFG_W + 1)'(need) > {1'b0, chunk_limit});
  assign fresh = fill_sum > {1'b0, chunk_limit};
  assign buf_raddr = {q_head.bank, idx};

  always_comb begin
    state_next = state;
    idx_next = idx;
    start_flag_next = start_flag;
    chunk_fill_next = chunk_fill;
    q_pop = 1'b0;
    buf_re = 1'b0;
    drop_push = 1'b0;
    nl_push = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_not_empty) begin
          if (word_empty) begin
            q_pop = 1'b1;
            if (q_head.eot) begin
              chunk_fill_next = '0;
            end
          end else if (too_long) begin
            if (room) begin
              drop_push = 1'b1;
              q_pop = 1'b1;
              if (q_head.eot) begin
                chunk_fill_next = '0;
              end
            end
          end else begin
            start_flag_next = fresh || (chunk_fill == '0);
            if (q_head.eot) begin
              chunk_fill_next = '0;
            end else if (fresh) begin
              chunk_fill_next = CFG_W'(need);
            end else begin
              chunk_fill_next = fill_sum[CFG_W-1:0];
            end
            idx_next = '0;
            state_next = BK_EMIT;
          end
        end
      end
      BK_EMIT: begin
        if (room) begin
          buf_re = 1'b1;
          if (idx == q_head.len - 1'b1) begin
            state_next = BK_NEWLINE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      BK_NEWLINE: begin
        if (!rd_pend && room) begin
          nl_push = 1'b1;
          q_pop = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      chunk_fill <= '0;
      chunk_limit <= CHUNK_LIMIT_RESET;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      chunk_fill <= chunk_fill_next;
      rd_pend <= buf_re;
      if (cfg_valid) begin
        chunk_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    start_flag <= start_flag_next;
    rd_first <= buf_re && (idx == '0);
  end

  // output queue
  always_comb begin
    oq_din = '{data: NEWLINE_BYTE, start: 1'b0, dropped: 1'b0, last: 1'b1};
    if (rd_pend) begin
      oq_din = '{data: buf_rdata, start: rd_first && start_flag, dropped: 1'b0, last: 1'b0};
    end else if (drop_push) begin
      oq_din = '{data: 8'h00, start: 1'b0, dropped: 1'b1, last: 1'b1};
    end
  end

  assign oq_push = rd_pend || drop_push || nl_push;
  assign empty = (oq_count == '0);
  assign oq_pop = pop && !empty;
  assign head = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= oq_din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr <= '0;
      oq_rd <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (!oq_push && oq_pop) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/word_chunk_packer.sv =====
// word chunk packer top level: front end, descriptor queue, word buffer, back end
// uses pkr_pkg, pkr_front, pkr_queue, pkr_ram, pkr_back
//
// input side is a queue: an item (in_byte, end_of_text) is taken when push is
// high and full is low. punctuation is deleted, whitespace ends a word, other
// bytes collect into a word. result side is a queue too: while empty is low the
// oldest result sits on out_byte/chunk_start/word_dropped/last and pop takes it.
// a finished word comes out as its bytes then a newline, with chunk_start on the
// first byte of each chunk; a word too long for the buffer or for one chunk
// gives one word_dropped result. last marks the final result of an input item.
// chunk_limit is written through cfg_valid/cfg_data (cfg_ready is always high).
// input items are taken one per cycle while the two-word queue has room. the
// back end places a word, reads its n bytes out of the word buffer and then
// queues the newline, which waits on the last read data; the n+1 results
// go to the result queue on consecutive cycles while it has room. when pop
// stays low the four-entry result queue fills, the back end waits, the word
// queue fills and full rises. synchronous reset empties both queues, clears
// word state and chunk fill and sets chunk_limit to 64; the word buffer needs
// no clearing pass.
module word_chunk_packer
  import pkr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             end_of_text,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             chunk_start,
  output logic             word_dropped,
  output logic             last
);

  logic              q_full, q_push, q_pop, q_not_empty;
  desc_t             q_din, q_head;
  logic              buf_we, buf_re;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]        buf_wdata, buf_rdata;
  result_t           res;

  assign cfg_ready = 1'b1;

  pkr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_byte    (in_byte),
    .end_of_text(end_of_text),
    .full       (full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_din      (q_din),
    .buf_we     (buf_we),
    .buf_waddr  (buf_waddr),
    .buf_wdata  (buf_wdata)
  );

  pkr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .din      (q_din),
    .pop      (q_pop),
    .dout     (q_head),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  pkr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(buf_waddr),
    .wdata(buf_wdata),
    .re   (buf_re),
    .raddr(buf_raddr),
    .rdata(buf_rdata)
  );

  pkr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .buf_re     (buf_re),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .empty      (empty),
    .pop        (pop),
    .head       (res)
  );

  assign out_byte = res.data;
  assign chunk_start = res.start;
  assign word_dropped = res.dropped;
  assign last = res.last;

endmodule

// ===== hdl/pkr_checker.sv =====
// port-level checks for the word chunk packer, bound to the top level
// uses pkr_pkg
module pkr_checker
  import pkr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       chunk_start,
  input logic       word_dropped,
  input logic       last
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last) &&
                          $stable(word_dropped) && $stable(chunk_start)))
    else $error("waiting result changed before pop");

  // a dropped word is a lone, byteless, final result
  a_drop_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && word_dropped) |-> (last && !chunk_start && out_byte == 8'h00))
    else $error("malformed dropped-word result");

  // every emitted word ends in a newline, and only there
  a_newline_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !word_dropped) |-> (last == (out_byte == NEWLINE_BYTE)))
    else $error("last flag does not match newline");

  // a chunk never opens on a newline
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && chunk_start) |-> (out_byte != NEWLINE_BYTE && !last))
    else $error("chunk start on newline");

endmodule

bind word_chunk_packer pkr_checker u_pkr_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .chunk_start (chunk_start),
  .word_dropped(word_dropped),
  .last        (last)
);

// ===== verif/pkr_checker.sv =====
// result checker for word_chunk_packer: tracks accepted items, predicts the wrapped output
// and compares each popped result; depends on pkr_pkg for result_t and byte_class_t
module pkr_scoreboard
  import pkr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        chunk_start,
  input  logic        word_dropped,
  input  logic        last,
  output int unsigned outstanding,
  output int unsigned mismatches,
  output int unsigned items_seen,
  output int unsigned bytes_seen,
  output int unsigned drops_seen
);

  localparam int WORD_MAX = 63;
  localparam logic [7:0] LF = 8'h0A;
  localparam logic [31:0] LIMIT_AT_RESET = 32'd64;

  logic [7:0]  word_buf [WORD_MAX];
  int unsigned word_len;
  bit          word_ovf;
  logic [31:0] fill;
  logic [31:0] chunk_limit;
  result_t     wrapped_q [$];
  result_t     batch [$];
  int unsigned n_bad;
  int unsigned n_items;
  int unsigned n_bytes;
  int unsigned n_drops;

  function automatic byte_class_t sort_byte(logic [7:0] b);
    if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) return CLS_SPACE;
    if ((b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
        (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E)) return CLS_PUNCT;
    return CLS_WORD;
  endfunction

  task automatic emit(logic [7:0] d, logic s, logic dr);
    result_t r;
    r.data = d;
    r.start = s;
    r.dropped = dr;
    r.last = 1'b0;
    batch.push_back(r);
  endtask

  task automatic flush_word();
    logic [63:0] need;
    need = 64'(word_len) + 64'd1;
    if (word_len == 0 && !word_ovf) return;
    if (word_ovf || need > 64'(chunk_limit)) begin
      emit(8'h00, 1'b0, 1'b1);
    end else begin
      // word does not fit the rest of this chunk: open a new one
      if (64'(fill) + need > 64'(chunk_limit)) fill = '0;
      for (int i = 0; i < word_len; i++) begin
        emit(word_buf[i], fill == 0 && i == 0, 1'b0);
      end
      emit(LF, 1'b0, 1'b0);
      fill = fill + need[31:0];
    end
    word_len = 0;
    word_ovf = 1'b0;
  endtask

  task automatic wrap_item(logic [7:0] b, logic eot);
    batch.delete();
    if (eot) begin
      flush_word();
      fill = '0;
    end else begin
      case (sort_byte(b))
        CLS_SPACE: flush_word();
        CLS_PUNCT: ;
        default: begin
          if (word_ovf || word_len >= WORD_MAX) begin
            word_ovf = 1'b1;
          end else begin
            word_buf[word_len] = b;
            word_len++;
          end
        end
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) wrapped_q.push_back(batch[i]);
  endtask

  task automatic check_result();
    result_t want;
    if (wrapped_q.size() == 0) begin
      $error("result with nothing predicted: out_byte %02h word_dropped %0b",
             out_byte, word_dropped);
      n_bad++;
      return;
    end
    want = wrapped_q.pop_front();
    if (out_byte !== want.data) begin
      $error("out_byte: expected %02h, got %02h", want.data, out_byte);
      n_bad++;
    end
    if (chunk_start !== want.start) begin
      $error("chunk_start: expected %0b, got %0b", want.start, chunk_start);
      n_bad++;
    end
    if (word_dropped !== want.dropped) begin
      $error("word_dropped: expected %0b, got %0b", want.dropped, word_dropped);
      n_bad++;
    end
    if (last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last);
      n_bad++;
    end
    if (want.dropped) n_drops++;
    else n_bytes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      word_len = 0;
      word_ovf = 1'b0;
      fill = '0;
      chunk_limit = LIMIT_AT_RESET;
      wrapped_q.delete();
    end else begin
      if (pop && !empty) check_result();
      if (cfg_valid && cfg_ready) chunk_limit = cfg_data;
      if (push && !full) begin
        wrap_item(in_byte, end_of_text);
        n_items++;
      end
    end
    // published after the edge so the stimulus side reads settled counts
    outstanding <= wrapped_q.size();
    mismatches <= n_bad;
    items_seen <= n_items;
    bytes_seen <= n_bytes;
    drops_seen <= n_drops;
  end

endmodule

// ===== verif/word_chunk_packer_tb.sv =====
// testbench top for word_chunk_packer: clock, reset, text stimulus under several chunk
// sizes with random gaps on both queues; uses pkr_pkg, word_chunk_packer and pkr_scoreboard
module word_chunk_packer_tb;
  import pkr_pkg::*;

  // bound on the whole run: a few hundred items and their results, plus drains
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = 32'h0;
  logic        pop = 1'b0;
  logic        full;
  logic        cfg_ready;
  logic        empty;
  logic [7:0]  out_byte;
  logic        chunk_start;
  logic        word_dropped;
  logic        last;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned items_seen;
  int unsigned bytes_seen;
  int unsigned drops_seen;
  int unsigned fed;
  int unsigned sizes_used;
  int unsigned cycles;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;

  word_chunk_packer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .end_of_text(end_of_text), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .empty(empty), .pop(pop), .out_byte(out_byte),
    .chunk_start(chunk_start), .word_dropped(word_dropped), .last(last)
  );

  pkr_scoreboard chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .end_of_text(end_of_text), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .empty(empty), .pop(pop), .out_byte(out_byte),
    .chunk_start(chunk_start), .word_dropped(word_dropped), .last(last),
    .outstanding(outstanding), .mismatches(mismatches), .items_seen(items_seen),
    .bytes_seen(bytes_seen), .drops_seen(drops_seen)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    pop <= !rx_gaps || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_of(byte_class_t c);
    logic [7:0] b;
    do b = 8'($urandom); while (classify(b) != c);
    return b;
  endfunction

  // push stays high from one item to the next unless a gap is drawn
  task automatic send_item(logic [7:0] b, logic e);
    while (tx_gaps && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    end_of_text <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    if (e || classify(b) != CLS_PUNCT) fed++;
  endtask

  task automatic send_word(int unsigned len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(pick_of(CLS_PUNCT), 1'b0);
      send_item(pick_of(CLS_WORD), 1'b0);
    end
  endtask

  task automatic run_text(int unsigned budget);
    int unsigned goal;
    int unsigned r;
    int unsigned len;
    goal = fed + budget;
    while (fed < goal) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_item(8'($urandom), $urandom_range(0, 19) == 0);
      end else begin
        // mostly short words, some near or past the buffer size
        r = $urandom_range(0, 99);
        if (r < 6) len = $urandom_range(60, 66);
        else if (r < 20) len = $urandom_range(13, 30);
        else len = $urandom_range(1, 12);
        send_word(len);
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_item(8'($urandom), 1'b1);
        end else begin
          send_item(pick_of(CLS_SPACE), 1'b0);
          if (r < 20) send_item(pick_of(CLS_SPACE), 1'b0);
        end
      end
    end
  endtask

  // sender holds off until every predicted result is out, then lets the block settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_chunk_limit(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sizes_used++;
  endtask

  initial begin
    logic [8:0] opening [24];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // bit 8 is end_of_text; reset chunk size
    opening = '{9'h000, 9'h0FF, 9'h07F, 9'h02E, 9'h080, 9'h020, 9'h020, 9'h061,
                9'h021, 9'h07E, 9'h062, 9'h009, 9'h00D, 9'h041, 9'h00A, 9'h05A,
                9'h1FF, 9'h100, 9'h001, 9'h07B, 9'h030, 9'h039, 9'h00B, 9'h00C};
    foreach (opening[i]) send_item(opening[i][7:0], opening[i][8]);

    // steady stretch on both sides
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_chunk_limit(32'hFFFF_FFFF);
    run_text(50);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // lowered while the chunk is likely already past the new size
    set_chunk_limit(32'd20);
    run_text(40);
    set_chunk_limit(32'd16);
    run_text(40);
    set_chunk_limit(32'd3);
    run_text(25);
    set_chunk_limit(32'd0);
    run_text(15);
    set_chunk_limit(32'd1000);
    run_text(50);
    drain();

    $display("fed %0d text items (%0d accepted in all) under %0d chunk sizes",
             fed, items_seen, sizes_used);
    $display("checked %0d output bytes and %0d dropped words", bytes_seen, drops_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pkr_pkg.sv
hdl/pkr_ram.sv
hdl/pkr_front.sv
hdl/pkr_queue.sv
hdl/pkr_back.sv
hdl/word_chunk_packer.sv
hdl/pkr_checker.sv
verif/pkr_checker.sv
verif/word_chunk_packer_tb.sv
